@@ hw/rtl/spa_pkg.sv @@
`timescale 1ns / 1ps

package spa_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the channels.
  localparam int OP_FW    = 3;
  localparam int IDX_FW   = 7;
  localparam int EDATA_FW = 32;
  localparam int STAT_FW  = 3;
  localparam int SLOT_FW  = 6;
  localparam int SDATA_FW = 32;
  localparam int CNT_FW   = 7;

  // Internal widths follow the pool size.
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  // The used map is searched in groups of eight bits.
  localparam int GRP_W  = 8;
  localparam int GRP_LW = 3;
  localparam int GRP_N  = (NUM_SLOTS + GRP_W - 1) / GRP_W;
  localparam int GRP_IW = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int VEC_W  = GRP_N * GRP_W;

  // Command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [OP_FW-1:0] {
    OP_PUT     = 3'd0,
    OP_FREE    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_RESTART = 3'd3,
    OP_WALK    = 3'd4
  } op_t;

  typedef enum logic [STAT_FW-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_RANGE    = 3'd2,
    STAT_FREE     = 3'd3,
    STAT_WALK_END = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_FREE,
    CMD_FREE_RANGE,
    CMD_CLEAR,
    CMD_RESTART,
    CMD_WALK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SLOT_W-1:0]     idx;
    logic [DATA_WIDTH-1:0] data;
  } cmd_t;

endpackage

@@ hw/rtl/spa_chan_if.sv @@
`timescale 1ns / 1ps

interface spa_in_if;
  logic                                valid;
  logic                                ready;
  logic [spa_pkg::OP_FW-1:0]    operation;
  logic [spa_pkg::IDX_FW-1:0]   slot_index;
  logic [spa_pkg::EDATA_FW-1:0] entry_data;

  modport source (output valid, output operation, output slot_index, output entry_data,
                  input ready);
  modport sink (input valid, input operation, input slot_index, input entry_data,
                output ready);
endinterface

interface spa_out_if;
  logic                                valid;
  logic                                ready;
  logic [spa_pkg::STAT_FW-1:0]  status;
  logic [spa_pkg::SLOT_FW-1:0]  slot;
  logic [spa_pkg::SDATA_FW-1:0] slot_data;
  logic [spa_pkg::CNT_FW-1:0]   used_count;
  logic                                last_of_walk;

  modport source (output valid, output status, output slot, output slot_data,
                  output used_count, output last_of_walk, input ready);
  modport sink (input valid, input status, input slot, input slot_data,
                input used_count, input last_of_walk, output ready);
endinterface

@@ hw/rtl/slot_pool_allocator_with_walk.sv @@
`timescale 1ns / 1ps

// Channel   Port     Role   Word
// input     in_ch    sink   operation, slot_index, entry_data
// result    out_ch   source status, slot, slot_data, used_count, last_of_walk
//
// Each input word yields exactly one result word, in order.
// The back end answers free, clear, walk restart, unused codes and a walk next after the
// walk has ended from the idle state; put and the walk next that finds the end go through
// the used-map search (scan, then pick); a walk next that visits a slot then also reads
// the store. A two-word command queue lets input be taken while the back end or the
// result register stalls. Synchronous active-low reset frees every slot and rewinds.
module slot_pool_allocator_with_walk (
  input  logic      clk,
  input  logic      rst_n,
  spa_in_if.sink    in_ch,
  spa_out_if.source out_ch
);

  logic                 push_valid;
  logic                 push_ready;
  spa_pkg::cmd_t push_cmd;
  logic                 pop_valid;
  logic                 pop_ready;
  spa_pkg::cmd_t pop_cmd;

  spa_front u_front (
    .in_ch     (in_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  spa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  spa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_cmd  (pop_cmd),
    .out_ch   (out_ch)
  );

endmodule

@@ hw/rtl/spa_ram.sv @@
`timescale 1ns / 1ps

module spa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/spa_front.sv @@
`timescale 1ns / 1ps

module spa_front (
  spa_in_if.sink                  in_ch,
  output logic                    push_valid,
  input  logic                    push_ready,
  output spa_pkg::cmd_t    push_cmd
);

  spa_pkg::op_t op;

  assign op          = spa_pkg::op_t'(in_ch.operation);
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_cmd.idx  = spa_pkg::SLOT_W'(in_ch.slot_index);
    push_cmd.data = spa_pkg::DATA_WIDTH'(in_ch.entry_data);
    unique case (op)
      spa_pkg::OP_PUT:     push_cmd.kind = spa_pkg::CMD_PUT;
      spa_pkg::OP_FREE: begin
        // Range is settled here so that the back end never indexes past the map.
        if (32'(in_ch.slot_index) >= 32'(spa_pkg::NUM_SLOTS)) begin
          push_cmd.kind = spa_pkg::CMD_FREE_RANGE;
        end else begin
          push_cmd.kind = spa_pkg::CMD_FREE;
        end
      end
      spa_pkg::OP_CLEAR:   push_cmd.kind = spa_pkg::CMD_CLEAR;
      spa_pkg::OP_RESTART: push_cmd.kind = spa_pkg::CMD_RESTART;
      spa_pkg::OP_WALK:    push_cmd.kind = spa_pkg::CMD_WALK;
      default:             push_cmd.kind = spa_pkg::CMD_NOP;
    endcase
  end

endmodule

@@ hw/rtl/spa_queue.sv @@
`timescale 1ns / 1ps

module spa_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  spa_pkg::cmd_t push_cmd,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output spa_pkg::cmd_t pop_cmd
);

  spa_pkg::cmd_t            q_r [spa_pkg::Q_DEPTH];
  logic [spa_pkg::QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [spa_pkg::QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [spa_pkg::QC_W-1:0] count_r, count_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (count_r != spa_pkg::QC_W'(spa_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == spa_pkg::QP_W'(spa_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == spa_pkg::QP_W'(spa_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spa_pkg::QC_W'(spa_pkg::Q_DEPTH))
    else $error("command queue holds more words than its depth");

endmodule

@@ hw/rtl/spa_back.sv @@
`timescale 1ns / 1ps

module spa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  spa_pkg::cmd_t pop_cmd,
  spa_out_if.source            out_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PICK, ST_READ} state_t;

  state_t                                  state_r, state_nxt;
  spa_pkg::cmd_t                    cur_r, cur_nxt;
  logic [spa_pkg::NUM_SLOTS-1:0]    used_map_r, used_map_nxt;
  logic [spa_pkg::CNT_W-1:0]        used_total_r, used_total_nxt;
  logic [spa_pkg::SLOT_W-1:0]       walk_pos_r, walk_pos_nxt;
  logic                                    walk_started_r, walk_started_nxt;
  logic                                    walk_done_r, walk_done_nxt;
  logic [spa_pkg::VEC_W-1:0]        vec_r, vec_nxt;
  logic [spa_pkg::GRP_N-1:0]        grp_any_r, grp_any_nxt;
  logic [spa_pkg::GRP_N-1:0]        grp_multi_r, grp_multi_nxt;
  logic [spa_pkg::GRP_N-1:0][spa_pkg::GRP_LW-1:0] grp_low_r, grp_low_nxt;

  logic                                    out_valid_r, out_valid_nxt;
  spa_pkg::status_t                 out_status_r, out_status_nxt;
  logic [spa_pkg::SLOT_FW-1:0]      out_slot_r, out_slot_nxt;
  logic [spa_pkg::SDATA_FW-1:0]     out_data_r, out_data_nxt;
  logic [spa_pkg::CNT_FW-1:0]       out_count_r, out_count_nxt;
  logic                                    out_last_r, out_last_nxt;

  logic                                    take;
  logic [spa_pkg::SLOT_W:0]         walk_start;
  logic                                    pick_found;
  logic                                    pick_above;
  logic [spa_pkg::GRP_IW-1:0]       pick_grp;
  logic [spa_pkg::SLOT_W-1:0]       pick_slot;
  logic                                    pick_last;
  logic                                    ram_we;
  logic [spa_pkg::DATA_WIDTH-1:0]   ram_rdata;

  assign pop_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign take      = pop_valid && pop_ready;
  assign walk_start = walk_started_r ? ({1'b0, walk_pos_r} + 1'b1) : '0;

  // Lowest nonempty group wins; anything seen before it lies above it.
  always_comb begin
    pick_found = 1'b0;
    pick_above = 1'b0;
    pick_grp   = '0;
    for (int i = spa_pkg::GRP_N - 1; i >= 0; i--) begin
      if (grp_any_r[i]) begin
        pick_above = pick_found;
        pick_found = 1'b1;
        pick_grp   = spa_pkg::GRP_IW'(i);
      end
    end
    pick_slot = spa_pkg::SLOT_W'({pick_grp, grp_low_r[pick_grp]});
    pick_last = !pick_above && !grp_multi_r[pick_grp];
  end

  always_comb begin
    logic [spa_pkg::GRP_W-1:0] bits;

    state_nxt        = state_r;
    cur_nxt          = cur_r;
    used_map_nxt     = used_map_r;
    used_total_nxt   = used_total_r;
    walk_pos_nxt     = walk_pos_r;
    walk_started_nxt = walk_started_r;
    walk_done_nxt    = walk_done_r;
    vec_nxt          = vec_r;
    grp_any_nxt      = grp_any_r;
    grp_multi_nxt    = grp_multi_r;
    grp_low_nxt      = grp_low_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_slot_nxt     = out_slot_r;
    out_data_nxt     = out_data_r;
    out_count_nxt    = out_count_r;
    out_last_nxt     = out_last_r;
    ram_we           = 1'b0;
    bits             = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          cur_nxt        = pop_cmd;
          out_status_nxt = spa_pkg::STAT_OK;
          out_slot_nxt   = '0;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b0;
          out_valid_nxt  = 1'b1;
          case (pop_cmd.kind)
            spa_pkg::CMD_PUT: begin
              for (int i = 0; i < spa_pkg::VEC_W; i++) begin
                vec_nxt[i] = (i < spa_pkg::NUM_SLOTS) ? !used_map_r[i] : 1'b0;
              end
              out_valid_nxt = 1'b0;
              state_nxt     = ST_SCAN;
            end
            spa_pkg::CMD_WALK: begin
              if (walk_done_r) begin
                out_status_nxt = spa_pkg::STAT_WALK_END;
              end else begin
                for (int i = 0; i < spa_pkg::VEC_W; i++) begin
                  vec_nxt[i] = (i < spa_pkg::NUM_SLOTS) ?
                               (used_map_r[i] &&
                                ((spa_pkg::SLOT_W + 1)'(i) >= walk_start)) : 1'b0;
                end
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SCAN;
              end
            end
            spa_pkg::CMD_FREE: begin
              if (!used_map_r[pop_cmd.idx]) begin
                out_status_nxt = spa_pkg::STAT_FREE;
              end else begin
                used_map_nxt[pop_cmd.idx] = 1'b0;
                used_total_nxt            = used_total_r - 1'b1;
              end
            end
            spa_pkg::CMD_FREE_RANGE: out_status_nxt = spa_pkg::STAT_RANGE;
            spa_pkg::CMD_CLEAR: begin
              used_map_nxt   = '0;
              used_total_nxt = '0;
            end
            spa_pkg::CMD_RESTART: begin
              walk_pos_nxt     = '0;
              walk_started_nxt = 1'b0;
              walk_done_nxt    = 1'b0;
            end
            default: ;
          endcase
          out_count_nxt = spa_pkg::CNT_FW'(used_total_nxt);
        end
      end

      ST_SCAN: begin
        for (int g = 0; g < spa_pkg::GRP_N; g++) begin
          bits             = vec_r[g * spa_pkg::GRP_W +: spa_pkg::GRP_W];
          grp_any_nxt[g]   = |bits;
          grp_multi_nxt[g] = |(bits & (bits - 1'b1));
          grp_low_nxt[g]   = '0;
          for (int b = spa_pkg::GRP_W - 1; b >= 0; b--) begin
            if (bits[b]) begin
              grp_low_nxt[g] = spa_pkg::GRP_LW'(b);
            end
          end
        end
        state_nxt = ST_PICK;
      end

      ST_PICK: begin
        out_slot_nxt = '0;
        out_data_nxt = '0;
        out_last_nxt = 1'b0;
        state_nxt    = ST_IDLE;
        if (!pick_found) begin
          out_valid_nxt = 1'b1;
          if (cur_r.kind == spa_pkg::CMD_PUT) begin
            out_status_nxt = spa_pkg::STAT_FULL;
          end else begin
            walk_done_nxt  = 1'b1;
            out_status_nxt = spa_pkg::STAT_WALK_END;
          end
        end else if (cur_r.kind == spa_pkg::CMD_PUT) begin
          used_map_nxt[pick_slot] = 1'b1;
          used_total_nxt          = used_total_r + 1'b1;
          ram_we                  = 1'b1;
          out_valid_nxt           = 1'b1;
          out_status_nxt          = spa_pkg::STAT_OK;
          out_slot_nxt            = spa_pkg::SLOT_FW'(pick_slot);
        end else begin
          // The stored entry arrives from the RAM in the next cycle, in the read state.
          walk_pos_nxt     = pick_slot;
          walk_started_nxt = 1'b1;
          out_status_nxt   = spa_pkg::STAT_OK;
          out_slot_nxt     = spa_pkg::SLOT_FW'(pick_slot);
          out_last_nxt     = pick_last;
          state_nxt        = ST_READ;
        end
        out_count_nxt = spa_pkg::CNT_FW'(used_total_nxt);
      end

      ST_READ: begin
        out_data_nxt  = spa_pkg::SDATA_FW'(ram_rdata);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      used_map_r     <= '0;
      used_total_r   <= '0;
      walk_pos_r     <= '0;
      walk_started_r <= 1'b0;
      walk_done_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      used_map_r     <= used_map_nxt;
      used_total_r   <= used_total_nxt;
      walk_pos_r     <= walk_pos_nxt;
      walk_started_r <= walk_started_nxt;
      walk_done_r    <= walk_done_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    vec_r        <= vec_nxt;
    grp_any_r    <= grp_any_nxt;
    grp_multi_r  <= grp_multi_nxt;
    grp_low_r    <= grp_low_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  spa_ram #(
    .WIDTH(spa_pkg::DATA_WIDTH),
    .DEPTH(spa_pkg::NUM_SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pick_slot),
    .wdata(cur_r.data),
    .raddr(pick_slot),
    .rdata(ram_rdata)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.slot_data    = out_data_r;
  assign out_ch.used_count   = out_count_r;
  assign out_ch.last_of_walk = out_last_r;

  a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_total_r) == $countones(used_map_r))
    else $error("used count differs from the number of used slots");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result register busy while an operation is in flight");

  a_put_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK && pick_found && cur_r.kind == spa_pkg::CMD_PUT)
    |=> used_map_r[$past(pick_slot)])
    else $error("slot taken by put is not marked used");

endmodule

@@ verif/tb_slot_pool_allocator_with_walk.sv @@
`timescale 1ns / 1ps

module tb_slot_pool_allocator_with_walk;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 1400;

  typedef struct {
    spa_pkg::status_t             status;
    logic [spa_pkg::SLOT_FW-1:0]  slot;
    logic [spa_pkg::SDATA_FW-1:0] slot_data;
    logic [spa_pkg::CNT_FW-1:0]   used_count;
    logic                         last_of_walk;
  } pool_result_t;

  logic clk;
  logic rst_n;

  spa_in_if  in_ch ();
  spa_out_if out_ch ();

  slot_pool_allocator_with_walk u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the pool, updated as each word is accepted.
  logic [spa_pkg::NUM_SLOTS-1:0]  pool_used;
  logic [spa_pkg::DATA_WIDTH-1:0] pool_data [spa_pkg::NUM_SLOTS];
  int                             pool_count;
  int                             walk_at;
  logic                           walk_begun;
  logic                           walk_over;

  pool_result_t pending_results [$];

  int failures;
  int words_accepted;
  int results_checked;
  int full_answers;
  int walk_ends;
  int rejected_frees;
  int unused_words;
  int burst_left;
  int idle_cycles;
  int stall_cycle;
  int stall_mode;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int lowest_slot(int from, logic want);
    for (int i = from; i < spa_pkg::NUM_SLOTS; i++) begin
      if (pool_used[i] == want) return i;
    end
    return spa_pkg::NUM_SLOTS;
  endfunction

  function automatic pool_result_t predict_pool_op(logic [spa_pkg::OP_FW-1:0] op,
                                                   logic [spa_pkg::IDX_FW-1:0] idx,
                                                   logic [spa_pkg::EDATA_FW-1:0] data);
    pool_result_t r;
    int           s;
    r.status       = spa_pkg::STAT_OK;
    r.slot         = '0;
    r.slot_data    = '0;
    r.last_of_walk = 1'b0;
    case (op)
      spa_pkg::OP_PUT: begin
        s = lowest_slot(0, 1'b0);
        if (s == spa_pkg::NUM_SLOTS) begin
          r.status = spa_pkg::STAT_FULL;
          full_answers++;
        end else begin
          pool_used[s] = 1'b1;
          pool_data[s] = data[spa_pkg::DATA_WIDTH-1:0];
          pool_count++;
          r.slot = s[spa_pkg::SLOT_FW-1:0];
        end
      end
      spa_pkg::OP_FREE: begin
        if (idx >= spa_pkg::NUM_SLOTS) begin
          r.status = spa_pkg::STAT_RANGE;
          rejected_frees++;
        end else if (!pool_used[idx]) begin
          r.status = spa_pkg::STAT_FREE;
          rejected_frees++;
        end else begin
          pool_used[idx] = 1'b0;
          pool_count--;
        end
      end
      spa_pkg::OP_CLEAR: begin
        pool_used  = '0;
        pool_count = 0;
      end
      spa_pkg::OP_RESTART: begin
        walk_at    = 0;
        walk_begun = 1'b0;
        walk_over  = 1'b0;
      end
      spa_pkg::OP_WALK: begin
        if (walk_over) begin
          r.status = spa_pkg::STAT_WALK_END;
          walk_ends++;
        end else begin
          s = lowest_slot(walk_begun ? walk_at + 1 : 0, 1'b1);
          if (s == spa_pkg::NUM_SLOTS) begin
            walk_over = 1'b1;
            r.status  = spa_pkg::STAT_WALK_END;
            walk_ends++;
          end else begin
            walk_at        = s;
            walk_begun     = 1'b1;
            r.slot         = s[spa_pkg::SLOT_FW-1:0];
            r.slot_data    = pool_data[s];
            r.last_of_walk = (lowest_slot(s + 1, 1'b1) == spa_pkg::NUM_SLOTS);
          end
        end
      end
      default: unused_words++;
    endcase
    r.used_count = pool_count[spa_pkg::CNT_FW-1:0];
    return r;
  endfunction

  // Sender: words go out in bursts, with the valid line sometimes dropped between bursts.
  task automatic send_word(logic [spa_pkg::OP_FW-1:0] op, logic [spa_pkg::IDX_FW-1:0] idx,
                           logic [spa_pkg::EDATA_FW-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.operation  = op;
    in_ch.slot_index = idx;
    in_ch.entry_data = data;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_pool_op(op, idx, data));
    words_accepted++;
  endtask

  function automatic logic [spa_pkg::IDX_FW-1:0] any_used_slot();
    int taken [$];
    for (int i = 0; i < spa_pkg::NUM_SLOTS; i++) begin
      if (pool_used[i]) taken.push_back(i);
    end
    if (taken.size() == 0) begin
      return spa_pkg::IDX_FW'($urandom_range(0, spa_pkg::NUM_SLOTS - 1));
    end
    return spa_pkg::IDX_FW'(taken[$urandom_range(0, taken.size() - 1)]);
  endfunction

  function automatic logic [spa_pkg::IDX_FW-1:0] any_index();
    return spa_pkg::IDX_FW'($urandom);
  endfunction

  function automatic logic [spa_pkg::EDATA_FW-1:0] entry_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return spa_pkg::EDATA_FW'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_word(spa_pkg::OP_WALK, 7'd0, 32'd0);
    send_word(spa_pkg::OP_WALK, 7'd0, 32'd0);
    send_word(spa_pkg::OP_FREE, 7'd0, $urandom);
    send_word(spa_pkg::OP_FREE, 7'd64, $urandom);
    send_word(spa_pkg::OP_FREE, 7'd127, $urandom);
    send_word(spa_pkg::OP_PUT, any_index(), 32'h0000_0000);
    send_word(spa_pkg::OP_PUT, any_index(), 32'hFFFF_FFFF);
    send_word(spa_pkg::OP_PUT, any_index(), 32'hA5A5_A5A5);
    send_word(spa_pkg::OP_PUT, any_index(), 32'h5A5A_5A5A);
    send_word(3'd5, any_index(), $urandom);
    send_word(3'd6, any_index(), $urandom);
    send_word(3'd7, any_index(), $urandom);
    // Free and put while a walk is in progress: the walk keeps its place.
    send_word(spa_pkg::OP_RESTART, any_index(), $urandom);
    send_word(spa_pkg::OP_WALK, any_index(), $urandom);
    send_word(spa_pkg::OP_FREE, 7'd1, $urandom);
    send_word(spa_pkg::OP_WALK, any_index(), $urandom);
    send_word(spa_pkg::OP_PUT, any_index(), 32'h1234_5678);
    send_word(spa_pkg::OP_WALK, any_index(), $urandom);
    send_word(spa_pkg::OP_WALK, any_index(), $urandom);
    // Clear in the middle of a walk leaves the walk position alone.
    send_word(spa_pkg::OP_RESTART, any_index(), $urandom);
    send_word(spa_pkg::OP_WALK, any_index(), $urandom);
    send_word(spa_pkg::OP_CLEAR, any_index(), $urandom);
    send_word(spa_pkg::OP_WALK, any_index(), $urandom);
    send_word(spa_pkg::OP_PUT, any_index(), 32'h8000_0001);
    send_word(spa_pkg::OP_FREE, 7'd63, $urandom);
  endtask

  task automatic test_fill_and_walk();
    send_word(spa_pkg::OP_RESTART, any_index(), $urandom);
    while (pool_count < spa_pkg::NUM_SLOTS) begin
      send_word(spa_pkg::OP_PUT, any_index(), entry_value());
    end
    repeat (2) send_word(spa_pkg::OP_PUT, any_index(), $urandom);
    repeat (spa_pkg::NUM_SLOTS + 2) send_word(spa_pkg::OP_WALK, any_index(), $urandom);
    send_word(spa_pkg::OP_FREE, 7'd63, $urandom);
    send_word(spa_pkg::OP_PUT, any_index(), 32'hDEAD_BEEF);
    send_word(spa_pkg::OP_FREE, 7'd0, $urandom);
    send_word(spa_pkg::OP_FREE, 7'd0, $urandom);
    send_word(spa_pkg::OP_RESTART, any_index(), $urandom);
    send_word(spa_pkg::OP_WALK, any_index(), $urandom);
    send_word(spa_pkg::OP_CLEAR, any_index(), $urandom);
    send_word(spa_pkg::OP_PUT, any_index(), $urandom);
  endtask

  task automatic test_random_mix();
    int counted;
    int seg_left;
    int put_bias;
    int r;
    int k;
    counted  = 0;
    seg_left = 0;
    put_bias = 50;
    while (counted < RANDOM_WORDS) begin
      // Each segment leans toward filling or draining the pool, or keeps a near balance.
      if (seg_left == 0) begin
        seg_left = 100;
        case ($urandom_range(0, 2))
          0:       put_bias = 20;
          1:       put_bias = 55;
          default: put_bias = 90;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_word(spa_pkg::OP_FW'($urandom_range(5, 7)), any_index(), $urandom);
      end else begin
        counted++;
        seg_left--;
        if (r < 3 && $urandom_range(0, 3) == 0) begin
          send_word(spa_pkg::OP_CLEAR, any_index(), $urandom);
        end else if (r < 9) begin
          send_word(spa_pkg::OP_RESTART, any_index(), $urandom);
        end else if (r < 35) begin
          send_word(spa_pkg::OP_WALK, any_index(), $urandom);
        end else if ($urandom_range(0, 99) < put_bias) begin
          send_word(spa_pkg::OP_PUT, any_index(), entry_value());
        end else begin
          k = $urandom_range(0, 9);
          if (k < 8) begin
            send_word(spa_pkg::OP_FREE, any_used_slot(), $urandom);
          end else if (k == 8) begin
            send_word(spa_pkg::OP_FREE, any_index(), $urandom);
          end else begin
            send_word(spa_pkg::OP_FREE,
                      spa_pkg::IDX_FW'($urandom_range(0, spa_pkg::NUM_SLOTS - 1)),
                      $urandom);
          end
        end
      end
    end
  endtask

  // Receiver stalls follow a mode that is redrawn at random, periodically.
  always @(negedge clk) begin
    stall_cycle++;
    if (stall_cycle % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ch.ready = 1'b1;
      1:       out_ch.ready = 1'($urandom_range(0, 1));
      2:       out_ch.ready = ($urandom_range(0, 3) == 0);
      default: out_ch.ready = ((stall_cycle % 8) < 3);
    endcase
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no expected result pending");
        failures++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("slot", 32'(want.slot), 32'(out_ch.slot));
        check_field("slot_data", want.slot_data, out_ch.slot_data);
        check_field("used_count", 32'(want.used_count), 32'(out_ch.used_count));
        check_field("last_of_walk", 32'(want.last_of_walk), 32'(out_ch.last_of_walk));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_slot_pool_allocator_with_walk NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = '0;
    in_ch.slot_index = '0;
    in_ch.entry_data = '0;
    out_ch.ready     = 1'b0;
    pool_used        = '0;
    pool_count       = 0;
    walk_at          = 0;
    walk_begun       = 1'b0;
    walk_over        = 1'b0;
    failures         = 0;
    words_accepted   = 0;
    results_checked  = 0;
    full_answers     = 0;
    walk_ends        = 0;
    rejected_frees   = 0;
    unused_words     = 0;
    burst_left       = 0;
    idle_cycles      = 0;
    stall_cycle      = 0;
    stall_mode       = 0;
    foreach (pool_data[i]) pool_data[i] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_and_walk();
    test_random_mix();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words (%0d with unused codes), checked %0d results.",
             words_accepted, unused_words, results_checked);
    $display("Saw %0d pool-full answers, %0d walk ends and %0d rejected frees.",
             full_answers, walk_ends, rejected_frees);
    if (failures == 0) begin
      $display("tb_slot_pool_allocator_with_walk OK");
    end else begin
      $display("tb_slot_pool_allocator_with_walk NOT OK");
    end
    $finish;
  end

endmodule
